/* hdl/pspt_pkg.sv */
// ----------------------------------------------------------------------------
// pspt_pkg
// Shared types and constants for the PC stride prefetch table.
// ----------------------------------------------------------------------------
`default_nettype none

package pspt_pkg;

  localparam int unsigned BLK_W      = 64;
  localparam int unsigned DEGREE_W   = 5;
  localparam logic [DEGREE_W-1:0] MAX_DEGREE = 5'd16;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request, register tag compares
    logic pick;      // resolve hit slot
    logic read;      // fetch last block and stride of the hit slot
    logic update;    // stride check, table rewrite, arm the run
    logic emit;      // move one prefetch into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic run_start;     // stride repeated and degree nonzero
    logic out_free;      // output register can take a prefetch now
    logic last_pending;  // next emit is the final one of the run
  } sts_t;

endpackage

`default_nettype wire

/* hdl/pspt_ctrl.sv */
// ----------------------------------------------------------------------------
// pspt_ctrl
// Sequencer: lookup, table update and the prefetch run of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pspt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output pspt_pkg::cmd_t     cmd,
  input  wire pspt_pkg::sts_t sts
);
  import pspt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PICK = 5'b00010,
    S_READ = 5'b00100,
    S_UPD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall    = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.pick    = (state_r == S_PICK);
  assign cmd.read    = (state_r == S_READ);
  assign cmd.update  = (state_r == S_UPD);
  assign cmd.emit    = (state_r == S_EMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PICK;
      S_PICK: state_nxt = S_READ;
      S_READ: state_nxt = S_UPD;
      S_UPD:  state_nxt = sts.run_start ? S_EMIT : S_IDLE;
      S_EMIT: if (sts.out_free && sts.last_pending) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // no run armed: straight back to idle
  a_upd_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !sts.run_start) |=> (state_r == S_IDLE))
    else $error("pspt_ctrl: update without run did not return to idle");

  // final emit ends the run and frees the input
  a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_pending) |=> !in_stall)
    else $error("pspt_ctrl: input still stalled after last prefetch");

  // a request is only taken when no other is in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_PICK) && in_stall)
    else $error("pspt_ctrl: capture did not start a lookup");

endmodule

`default_nettype wire

/* hdl/pspt_dp.sv */
// ----------------------------------------------------------------------------
// pspt_dp
// Datapath: recency-ordered entry slots, tag match, stride check, prefetch
// accumulator, degree register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pspt_dp #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pspt_pkg::cmd_t                cmd,
  output pspt_pkg::sts_t                     sts,
  input  wire logic [pspt_pkg::BLK_W-1:0]    in_miss_pc,
  input  wire logic [pspt_pkg::BLK_W-1:0]    in_miss_block,
  input  wire logic                          cfg_we,
  input  wire logic [pspt_pkg::DEGREE_W-1:0] cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pspt_pkg::BLK_W-1:0]         out_prefetch_block,
  output logic                               out_last_of_run
);
  import pspt_pkg::*;

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned TOP   = NUM_ENTRIES - 1;

  // slot k holds the entry of recency rank k (slot 0 = LRU)
  logic [BLK_W-1:0]       tag_r    [NUM_ENTRIES];
  logic [BLK_W-1:0]       last_r   [NUM_ENTRIES];
  logic [BLK_W-1:0]       stride_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [NUM_ENTRIES-1:0] match_r;

  logic [BLK_W-1:0]    pc_r, blk_r, sel_last_r, sel_stride_r, acc_r;
  logic [IDX_W-1:0]    idx_r, pick;
  logic [DEGREE_W-1:0] degree_r, deg_sat, cnt_r;
  logic [BLK_W-1:0]    new_stride;
  logic                stride_eq;
  logic                out_valid_r, out_last_r;
  logic [BLK_W-1:0]    out_block_r;

  assign new_stride = blk_r - sel_last_r;
  assign stride_eq  = (new_stride == sel_stride_r);
  assign deg_sat    = (degree_r > MAX_DEGREE) ? MAX_DEGREE : degree_r;

  assign sts.run_start    = stride_eq && (deg_sat != '0);
  assign sts.out_free     = !out_valid_r || !out_stall;
  assign sts.last_pending = (cnt_r == DEGREE_W'(1));

  assign out_valid          = out_valid_r;
  assign out_prefetch_block = out_block_r;
  assign out_last_of_run    = out_last_r;

  // entry slots; invalid slots read as the all-zero reset entry
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        match_r[k] <= valid_r[k] ? (tag_r[k] == in_miss_pc) : (in_miss_pc == '0);
      end
    end

    if (k == TOP) begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.update) begin
          tag_r[k]    <= pc_r;
          last_r[k]   <= blk_r;
          stride_r[k] <= new_stride;
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (cmd.update) begin
          valid_r[k] <= 1'b1;
        end
      end
    end else begin : g_low
      always_ff @(posedge clk) begin
        if (cmd.update && (IDX_W'(k) >= idx_r)) begin
          tag_r[k]    <= tag_r[k+1];
          last_r[k]   <= last_r[k+1];
          stride_r[k] <= stride_r[k+1];
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (cmd.update && (IDX_W'(k) >= idx_r)) begin
          valid_r[k] <= valid_r[k+1];
        end
      end
    end
  end

  // lowest matching slot wins; no match falls back to the LRU slot
  always_comb begin
    pick = '0;
    for (int k = NUM_ENTRIES - 1; k >= 0; k--) begin
      if (match_r[k]) pick = IDX_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pc_r  <= in_miss_pc;
      blk_r <= in_miss_block;
    end
    if (cmd.pick) begin
      idx_r <= pick;
    end
    if (cmd.read) begin
      sel_last_r   <= valid_r[idx_r] ? last_r[idx_r]   : '0;
      sel_stride_r <= valid_r[idx_r] ? stride_r[idx_r] : '0;
    end
    if (cmd.update) begin
      acc_r <= blk_r + sel_stride_r;
    end else if (cmd.emit) begin
      acc_r <= acc_r + sel_stride_r;
    end
    if (cmd.emit) begin
      out_block_r <= acc_r;
      out_last_r  <= (cnt_r == DEGREE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= DEGREE_W'(2);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) degree_r <= cfg_wdata;
      if (cmd.update) begin
        cnt_r <= stride_eq ? deg_sat : '0;
      end else if (cmd.emit) begin
        cnt_r <= cnt_r - DEGREE_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (cnt_r != '0))
    else $error("pspt_dp: emit with empty run count");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && (out_block_r == $past(acc_r)))
    else $error("pspt_dp: emitted prefetch not in output register");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (cnt_r <= MAX_DEGREE))
    else $error("pspt_dp: run count above maximum degree");

endmodule

`default_nettype wire

/* hdl/pc_stride_prefetch_table.sv */
// ----------------------------------------------------------------------------
// pc_stride_prefetch_table
// Per-PC constant-stride prefetcher with an LRU-ordered, fully associative
// reference prediction table.
// ----------------------------------------------------------------------------
// Each miss request (PC, block) goes through accept with a parallel tag
// compare, hit-slot priority encode, entry read, then stride check and table
// rewrite before its first prefetch can leave. The run then sends one
// prefetch per cycle while out_stall is low; in_stall stays high for the
// whole request. The sequencer handles one request at a time, and the single
// output register lets the next request start while the last prefetch still
// waits downstream. The degree register (cfg_we/cfg_wdata, reset 2, values
// above 16 act as 16) is meant to be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_stride_prefetch_table #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // miss request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pspt_pkg::BLK_W-1:0]    in_miss_pc,
  input  wire logic [pspt_pkg::BLK_W-1:0]    in_miss_block,
  // prefetch request channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pspt_pkg::BLK_W-1:0]         out_prefetch_block,
  output logic                               out_last_of_run,
  // prefetch degree register
  input  wire logic                          cfg_we,
  input  wire logic [pspt_pkg::DEGREE_W-1:0] cfg_wdata
);
  import pspt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the request handshake and the step order
  pspt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // table, stride arithmetic and the output register
  pspt_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_miss_pc         (in_miss_pc),
    .in_miss_block      (in_miss_block),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_prefetch_block (out_prefetch_block),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

`default_nettype wire

/* sim/pspt_prefetch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspt_prefetch_checker
// Watches the miss, prefetch and degree ports of the stride prefetch table.
// It keeps its own copy of the table and LRU order, predicts the prefetch
// requests that each accepted miss should produce, and compares them in
// order with what the block sends out.
// ----------------------------------------------------------------------------

module pspt_prefetch_checker #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pspt_pkg::BLK_W-1:0]    in_miss_pc,
  input  logic [pspt_pkg::BLK_W-1:0]    in_miss_block,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pspt_pkg::BLK_W-1:0]    out_prefetch_block,
  input  logic                          out_last_of_run,
  input  logic                          cfg_we,
  input  logic [pspt_pkg::DEGREE_W-1:0] cfg_wdata,
  output int unsigned                   mismatches,
  output int unsigned                   prefetches_owed
);
  import pspt_pkg::*;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic             last;
  } prefetch_t;

  prefetch_t owed_q[$];

  logic [BLK_W-1:0]    tag_tbl[NUM_ENTRIES];
  logic [BLK_W-1:0]    last_blk_tbl[NUM_ENTRIES];
  logic [BLK_W-1:0]    stride_tbl[NUM_ENTRIES];
  int unsigned         rank_tbl[NUM_ENTRIES];
  logic [DEGREE_W-1:0] degree_reg;

  initial begin
    mismatches      = 0;
    prefetches_owed = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic clear_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tag_tbl[i]      = '0;
      last_blk_tbl[i] = '0;
      stride_tbl[i]   = '0;
      rank_tbl[i]     = i;
    end
    degree_reg = 5'd2;
    owed_q.delete();
  endtask

  // Lookup, stride check, prefetch run and table rewrite for one miss.
  task automatic predict_miss(input logic [BLK_W-1:0] pc, input logic [BLK_W-1:0] blk);
    int unsigned      slot;
    int unsigned      lru_slot;
    int unsigned      hit_rank;
    int unsigned      old_rank;
    int unsigned      runs;
    logic [BLK_W-1:0] fresh_stride;
    logic [BLK_W-1:0] addr;
    prefetch_t        p;
    slot     = 0;
    lru_slot = 0;
    hit_rank = NUM_ENTRIES;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (rank_tbl[i] == 0) lru_slot = i;
      // least recent matching tag wins
      if (tag_tbl[i] == pc && rank_tbl[i] < hit_rank) begin
        hit_rank = rank_tbl[i];
        slot     = i;
      end
    end
    if (hit_rank == NUM_ENTRIES) slot = lru_slot;

    fresh_stride = blk - last_blk_tbl[slot];
    runs = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg;
    if (fresh_stride == stride_tbl[slot]) begin
      addr = blk;
      for (int k = 1; k <= runs; k++) begin
        addr   = addr + stride_tbl[slot];
        p.blk  = addr;
        p.last = (k == runs);
        owed_q = {owed_q, p};
      end
    end

    tag_tbl[slot]      = pc;
    last_blk_tbl[slot] = blk;
    stride_tbl[slot]   = fresh_stride;
    old_rank = rank_tbl[slot];
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (rank_tbl[i] > old_rank) rank_tbl[i] = rank_tbl[i] - 1;
    end
    rank_tbl[slot] = NUM_ENTRIES - 1;
  endtask

  task automatic check_prefetch();
    prefetch_t exp_p;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("prefetch %h with none owed", out_prefetch_block));
    end else begin
      exp_p = owed_q.pop_front();
      if (out_prefetch_block !== exp_p.blk)
        report_mismatch($sformatf("prefetch_block %h, want %h",
                                  out_prefetch_block, exp_p.blk));
      if (out_last_of_run !== exp_p.last)
        report_mismatch($sformatf("last_of_run %b, want %b (block %h)",
                                  out_last_of_run, exp_p.last, exp_p.blk));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
    end else begin
      if (cfg_we) degree_reg = cfg_wdata;
      // outgoing first: a result at this edge never belongs to a miss taken now
      if (out_valid && !out_stall) check_prefetch();
      if (in_valid && !in_stall) predict_miss(in_miss_pc, in_miss_block);
    end
    prefetches_owed = owed_q.size();
  end

endmodule

/* sim/pc_stride_prefetch_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_stride_prefetch_table_tb
// Regression bench for the PC stride prefetch table. A directed opening
// covers degree limits, wrapping and negative strides, duplicate zero tags
// and the zero stride; random streams of constant-stride misses with noise
// follow under three handshake pressure profiles. A separate checker
// predicts and compares every prefetch request.
// ----------------------------------------------------------------------------

module pc_stride_prefetch_table_tb;

  import pspt_pkg::*;

  localparam int unsigned ENTRIES       = 16;
  localparam int unsigned STREAMS       = 20;
  localparam int unsigned BLOCK_ITEMS   = 50;
  // a miss that yields no prefetch still runs lookup and update; leave margin before cfg writes
  localparam int unsigned SETTLE_CYCLES = 8;
  // cycles with no request moving on either side before we give up
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam logic [BLK_W-1:0] ALL_ONES = '1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [BLK_W-1:0]    in_miss_pc;
  logic [BLK_W-1:0]    in_miss_block;
  logic                out_valid;
  logic                out_stall;
  logic [BLK_W-1:0]    out_prefetch_block;
  logic                out_last_of_run;
  logic                cfg_we;
  logic [DEGREE_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned prefetches_owed;

  // idle percentages for the miss sender and the prefetch receiver
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  int unsigned idle_cycles = 0;

  // miss streams: each PC walks its blocks with its own stride
  logic [BLK_W-1:0] stream_pc[STREAMS];
  logic [BLK_W-1:0] stream_next[STREAMS];
  logic [BLK_W-1:0] stream_step[STREAMS];

  always #10 clk = ~clk;

  pc_stride_prefetch_table #(
    .NUM_ENTRIES(ENTRIES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_miss_pc        (in_miss_pc),
    .in_miss_block     (in_miss_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prefetch_block(out_prefetch_block),
    .out_last_of_run   (out_last_of_run),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  pspt_prefetch_checker #(
    .NUM_ENTRIES(ENTRIES)
  ) checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_miss_pc        (in_miss_pc),
    .in_miss_block     (in_miss_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prefetch_block(out_prefetch_block),
    .out_last_of_run   (out_last_of_run),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .prefetches_owed   (prefetches_owed)
  );

  // Receiver back-pressure, redrawn every cycle, independent of out_valid.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any accepted request on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [BLK_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short strides either way, some zero, some anywhere in the space.
  function automatic logic [BLK_W-1:0] pick_stride();
    case ($urandom_range(9))
      0:       return '0;
      1:       return rand64();
      2, 3:    return -BLK_W'($urandom_range(1, 64));
      default: return BLK_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [DEGREE_W-1:0] pick_degree();
    case ($urandom_range(7))
      0:       return '0;
      1:       return DEGREE_W'($urandom_range(17, 31));  // saturates at 16
      default: return DEGREE_W'($urandom_range(1, 8));
    endcase
  endfunction

  // One miss request: random sender gaps, then hold until accepted.
  task automatic send_miss(input logic [BLK_W-1:0] pc, input logic [BLK_W-1:0] blk);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      in_miss_pc    <= rand64();  // payload is don't-care while idle
      in_miss_block <= rand64();
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_miss_pc    <= pc;
    in_miss_block <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending, let every owed prefetch drain, then let the sequencer
  // finish any miss that produces nothing. Ends on a falling edge.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (prefetches_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_degree(input logic [DEGREE_W-1:0] degree);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= degree;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly hot streams, some cold ones (forces LRU eviction), some noise
  // and some stream PCs hit with an off-pattern block.
  task automatic random_miss();
    int unsigned s;
    int unsigned roll;
    roll = $urandom_range(99);
    s = ($urandom_range(3) == 0) ? $urandom_range(STREAMS - 1) : $urandom_range(9);
    if (roll < 82) begin
      if ($urandom_range(99) < 8) stream_step[s] = pick_stride();
      send_miss(stream_pc[s], stream_next[s]);
      stream_next[s] = stream_next[s] + stream_step[s];
    end else if (roll < 91) begin
      send_miss(rand64(), rand64());
    end else begin
      send_miss(stream_pc[s], rand64());
    end
  endtask

  initial begin
    logic [BLK_W-1:0] c_pc;
    logic [BLK_W-1:0] c_blk;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_miss_pc    = '0;
    in_miss_block = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    send_idle_pct = 24;
    stall_pct     = 51;

    // stream 0 shares the reset tag, stream 1 the all-ones PC
    for (int i = 0; i < STREAMS; i++) begin
      stream_pc[i]   = (i == 0) ? '0 : (i == 1) ? ALL_ONES : rand64();
      stream_next[i] = rand64();
      stream_step[i] = pick_stride();
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed opening, reset degree of 2 ---
    // PC zero right after reset hits the LRU entry; the zero stride repeats,
    // so two copies of block zero come out.
    send_miss('0, '0);
    // all-ones PC and block, then a stride of one that repeats
    send_miss(ALL_ONES, ALL_ONES);
    send_miss(ALL_ONES, '0);
    send_miss(ALL_ONES, 64'd1);
    // PC zero again: several stale zero tags, least recent must win
    send_miss('0, 64'h40);
    // prefetch addresses wrap past the top of the block space
    send_miss(64'h0000_7fff_0000_1234, ALL_ONES - 2);
    send_miss(64'h0000_7fff_0000_1234, ALL_ONES - 1);
    send_miss(64'h0000_7fff_0000_1234, ALL_ONES);
    // negative stride
    send_miss(64'h8000_0000_0000_0000, 64'd100);
    send_miss(64'h8000_0000_0000_0000, 64'd90);
    send_miss(64'h8000_0000_0000_0000, 64'd80);
    // alternating bit patterns on both fields
    send_miss(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_miss(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);

    // degree extremes on one stride-7 stream
    c_pc  = 64'hdead_beef_0000_0040;
    c_blk = 64'd1000;
    set_degree(5'd16);
    repeat (3) begin
      send_miss(c_pc, c_blk);
      c_blk = c_blk + 7;
    end
    set_degree(5'd31);  // above the cap
    send_miss(c_pc, c_blk);
    c_blk = c_blk + 7;
    set_degree(5'd17);
    send_miss(c_pc, c_blk);
    c_blk = c_blk + 7;
    // degree zero: no prefetches, but the entry keeps learning
    set_degree(5'd0);
    repeat (2) begin
      send_miss(c_pc, c_blk);
      c_blk = c_blk + 7;
    end
    set_degree(5'd1);
    send_miss(c_pc, c_blk);

    // --- random streams under three pressure profiles ---
    // profile 0: sender 24 / receiver 51, 1: swapped, 2: no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 51 : 0;
      stall_pct     = (phase == 0) ? 51 : (phase == 1) ? 24 : 0;
      // each block starts from a full drain and a fresh degree
      for (int b = 0; b < 3; b++) begin
        set_degree(pick_degree());
        repeat (BLOCK_ITEMS) random_miss();
      end
    end

    drain_block();
    if (mismatches == 0 && prefetches_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pspt_pkg.sv
hdl/pspt_ctrl.sv
hdl/pspt_dp.sv
hdl/pc_stride_prefetch_table.sv
sim/pspt_prefetch_checker.sv
sim/pc_stride_prefetch_table_tb.sv
